// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

   localparam int unsigned TickHz = 100000;
   localparam int unsigned RpmMax = 23'h7FFFFF;
   localparam int unsigned SpdMax = 17'h1FFFF;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SPEED_FLOOR = 2'd0;
   localparam logic [1:0] CSR_MIN_RPM     = 2'd1;
   localparam logic [1:0] CSR_SLIP_THR    = 2'd2;

   // Capture channel codes.
   localparam logic [1:0] CH_ENGINE = 2'd0;
   localparam logic [1:0] CH_WHEEL1 = 2'd1;
   localparam logic [1:0] CH_WHEEL2 = 2'd2;

   // Divider operand width.
   localparam int unsigned DivW = 32;
   localparam int unsigned DivCntW = 5;

   typedef struct packed {
      logic        start;
      logic        signed_op;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [DivW-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/wsd_if.sv =====
interface wsd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  channel;
   logic [15:0] stamp;
   modport source (output valid, channel, stamp, input ready);
   modport sink   (input valid, channel, stamp, output ready);
endinterface

interface wsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [22:0]        engine_rpm;
   logic [16:0]        speed_hz;
   logic signed [15:0] acceleration;
   logic signed [26:0] slip_permille;
   logic               slipping;
   logic               divide_fault;
   modport source (output valid, engine_rpm, speed_hz, acceleration, slip_permille,
                   slipping, divide_fault, input ready);
   modport sink   (input valid, engine_rpm, speed_hz, acceleration, slip_permille,
                   slipping, divide_fault, output ready);
endinterface

interface wsd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [26:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wsd_divider.sv =====
module wsd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wsd_pkg::div_req_type req,
   output wsd_pkg::div_rsp_type rsp
);
   import wsd_pkg::*;

   logic [DivW-1:0]    rem_ff, rem_in;
   logic [DivW-1:0]    quo_ff, quo_in;
   logic [DivW-1:0]    den_ff, den_in;
   logic               neg_ff, neg_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic [DivW:0]      trial;
   logic [DivW-1:0]    shifted;
   logic               a_neg, b_neg;

   // One restoring step per cycle on magnitudes; sign fixed at the end.
   always_comb begin
      a_neg   = req.signed_op & req.dividend[DivW-1];
      b_neg   = req.signed_op & req.divisor[DivW-1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      shifted = {rem_ff[DivW-2:0], quo_ff[DivW-1]};
      trial   = {1'b0, shifted} - {1'b0, den_ff};
      if (req.start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = a_neg ? (~req.dividend + 1'b1) : req.dividend;
         den_in  = b_neg ? (~req.divisor + 1'b1) : req.divisor;
         neg_in  = a_neg ^ b_neg;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!trial[DivW]) begin
            rem_in = trial[DivW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DivCntW'(DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) quo_in = ~quo_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff)) else $error("divider done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req.start && !busy_ff) |=> busy_ff) else $error("divider failed to start");

endmodule

// ===== rtl/wheel_slip_detector.sv =====
// An ignored channel or an engine arming edge goes straight to the result; an engine
// measuring edge first runs the frequency division. A wheel edge runs the frequency
// division if it measures, then the slip division unless the first-wheel acceleration
// is zero.
// Throughput: one transaction at a time; the next is taken in the cycle after the result leaves.
// Reset: synchronous, active high; clears armed flags, first stamps, history, threshold and result state.
module wheel_slip_detector (
   input logic       clock,
   input logic       reset,
   wsd_req_if.sink   req,
   wsd_rsp_if.source rsp,
   wsd_csr_if.sink   csr
);
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FREQ, ST_FWAIT, ST_UPDATE, ST_SWAIT, ST_FLAG, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [1:0]         ch_ff;
   logic [15:0]        stamp_ff;
   logic [2:0]         armed_ff;
   logic [15:0]        first_ff [3];
   logic [16:0]        hist_ff [4];
   logic [1:0]         slot_ff;
   logic [22:0]        rpm_ff;
   logic signed [26:0] slip_ff;
   logic               slipping_ff, fault_ff;
   logic [16:0]        speed_floor_ff;
   logic [22:0]        min_rpm_ff;
   logic signed [26:0] thr_ff;
   logic               rsp_valid_ff;
   logic               wheel_ff;

   div_req_type        dreq;
   div_rsp_type        drsp;
   logic               dstart;
   logic [DivW-1:0]    dnum, dden;
   logic               dsigned;

   logic [16:0]        period;
   logic [15:0]        pdiff;
   logic signed [15:0] a1, a2, acc;
   logic [16:0]        spd;
   logic [DivW-1:0]    q;
   logic [DivW+5:0]    rpm_wide;
   logic signed [31:0] num_slip;
   logic [16:0]        freq_sat;

   // Accelerations and speed from the histories; capture period, quotient scaling and slip numerator.
   always_comb begin
      a1  = slot_ff[0] ? 16'(hist_ff[0] - hist_ff[1]) : 16'(hist_ff[1] - hist_ff[0]);
      a2  = slot_ff[1] ? 16'(hist_ff[2] - hist_ff[3]) : 16'(hist_ff[3] - hist_ff[2]);
      acc = (a1 >= a2) ? a1 : a2;
      spd = (hist_ff[0] >= hist_ff[2]) ? hist_ff[0] : hist_ff[2];
      pdiff  = stamp_ff - first_ff[ch_ff];
      period = (pdiff == 16'd0) ? 17'h10000 : {1'b0, pdiff};
      q        = drsp.quotient;
      rpm_wide = 38'(q) * 38'd60;
      freq_sat = (q > DivW'(SpdMax)) ? 17'(SpdMax) : q[16:0];
      num_slip = (32'(a2) - 32'(a1)) * 32'sd1000;
   end

   // Divider launch selection.
   always_comb begin
      dstart  = 1'b0;
      dnum    = '0;
      dden    = '0;
      dsigned = 1'b0;
      if (state_ff == ST_FREQ) begin
         dstart = 1'b1;
         dnum   = DivW'(TickHz);
         dden   = DivW'(period);
      end else if (state_ff == ST_UPDATE && a1 != 16'sd0) begin
         dstart  = 1'b1;
         dsigned = 1'b1;
         dnum    = DivW'(num_slip);
         dden    = DivW'(32'(a1));
      end
      dreq.start     = dstart;
      dreq.signed_op = dsigned;
      dreq.dividend  = dnum;
      dreq.divisor   = dden;
   end

   wsd_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;

   // Sequencer and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         armed_ff       <= '0;
         first_ff       <= '{default: '0};
         hist_ff        <= '{default: '0};
         slot_ff        <= '0;
         rpm_ff         <= '0;
         slip_ff        <= '0;
         slipping_ff    <= 1'b0;
         fault_ff       <= 1'b0;
         speed_floor_ff <= '0;
         min_rpm_ff     <= '0;
         thr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         wheel_ff       <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CSR_SPEED_FLOOR: speed_floor_ff <= csr.data[16:0];
               CSR_MIN_RPM:     min_rpm_ff     <= csr.data[22:0];
               CSR_SLIP_THR:    thr_ff         <= csr.data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  ch_ff    <= req.channel;
                  stamp_ff <= req.stamp;
                  wheel_ff <= (req.channel == CH_WHEEL1) || (req.channel == CH_WHEEL2);
                  if (req.channel == 2'd3) begin
                     state_ff <= ST_OUT;
                  end else if (!armed_ff[req.channel]) begin
                     armed_ff[req.channel] <= 1'b1;
                     first_ff[req.channel] <= req.stamp;
                     state_ff <= (req.channel == CH_ENGINE) ? ST_OUT : ST_UPDATE;
                  end else begin
                     state_ff <= ST_FREQ;
                  end
               end
            end
            ST_FREQ: state_ff <= ST_FWAIT;
            ST_FWAIT: begin
               if (drsp.done) begin
                  armed_ff[ch_ff] <= 1'b0;
                  first_ff[ch_ff] <= stamp_ff;
                  if (ch_ff == CH_ENGINE) begin
                     rpm_ff   <= (rpm_wide > 38'(RpmMax)) ? 23'(RpmMax) : rpm_wide[22:0];
                     state_ff <= ST_OUT;
                  end else begin
                     hist_ff[{ch_ff == CH_WHEEL2, slot_ff[ch_ff == CH_WHEEL2]}] <= freq_sat;
                     slot_ff[ch_ff == CH_WHEEL2] <= ~slot_ff[ch_ff == CH_WHEEL2];
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_UPDATE: begin
               if (a1 == 16'sd0) begin
                  slip_ff  <= '0;
                  fault_ff <= 1'b1;
                  state_ff <= ST_FLAG;
               end else begin
                  fault_ff <= 1'b0;
                  state_ff <= ST_SWAIT;
               end
            end
            ST_SWAIT: begin
               if (drsp.done) begin
                  slip_ff  <= 27'(q);
                  state_ff <= ST_FLAG;
               end
            end
            ST_FLAG: begin
               slipping_ff <= (spd > speed_floor_ff) && (rpm_ff > min_rpm_ff) &&
                              (slip_ff > thr_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
               end else if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.engine_rpm    = rpm_ff;
   assign rsp.speed_hz      = spd;
   assign rsp.acceleration  = acc;
   assign rsp.slip_permille = slip_ff;
   assign rsp.slipping      = slipping_ff;
   assign rsp.divide_fault  = fault_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("input taken while result pending");
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      fault_ff |-> (slip_ff == 27'sd0)) else $error("fault with nonzero slip");
   a_engine_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !wheel_ff) |-> $stable(slip_ff))
      else $error("slip changed on engine edge");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !drsp.busy) else $error("divider busy when idle");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import wsd_pkg::*;

   // One expected result of the detector.
   typedef struct {
      logic [22:0]        engine_rpm;
      logic [16:0]        speed_hz;
      logic signed [15:0] acceleration;
      logic signed [26:0] slip_permille;
      logic               slipping;
      logic               divide_fault;
   } slip_result_type;

   // Tracks the capture and slip state of the detector and checks its results.
   class slip_scoreboard;
      slip_result_type    pending_results[$];
      int                 mismatches;
      logic [16:0]        speed_floor;
      logic [22:0]        min_rpm;
      int                 slip_limit;
      logic               armed[3];
      logic [15:0]        first_stamp[3];
      logic [16:0]        history[4];
      logic               slot[2];
      logic [22:0]        rpm;
      int                 slip;
      logic               slipping;
      logic               fault;

      function new();
         mismatches = 0;
         speed_floor = '0;
         min_rpm = '0;
         slip_limit = 0;
         for (int i = 0; i < 3; i++) begin
            armed[i] = 1'b0;
            first_stamp[i] = '0;
         end
         for (int i = 0; i < 4; i++) history[i] = '0;
         slot[0] = 1'b0;
         slot[1] = 1'b0;
         rpm = '0;
         slip = 0;
         slipping = 1'b0;
         fault = 1'b0;
      endfunction

      task report(string what, longint got, longint want);
         $display("error at %0t: %s is %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      function void write_reg(logic [1:0] index, logic [26:0] data);
         case (index)
            CSR_SPEED_FLOOR: speed_floor = data[16:0];
            CSR_MIN_RPM: min_rpm = data[22:0];
            CSR_SLIP_THR: slip_limit = int'(signed'(data));
            default: ;
         endcase
      endfunction

      // Returns the frequency of a measuring edge, or -1 on an arming edge.
      function int measure(int ch, logic [15:0] stamp);
         int unsigned period;
         if (!armed[ch]) begin
            first_stamp[ch] = stamp;
            armed[ch] = 1'b1;
            return -1;
         end
         period = 32'(16'(stamp - first_stamp[ch]));
         if (period == 0) period = 32'h10000;
         first_stamp[ch] = stamp;
         armed[ch] = 1'b0;
         return int'(TickHz / period);
      endfunction

      function int accel(int w);
         logic [16:0] diff;
         if (!slot[w]) diff = history[w*2+1] - history[w*2];
         else diff = history[w*2] - history[w*2+1];
         return int'(signed'(diff[15:0]));
      endfunction

      function logic [16:0] speed();
         return (history[0] >= history[2]) ? history[0] : history[2];
      endfunction

      function void note_capture(logic [1:0] channel, logic [15:0] stamp);
         slip_result_type r;
         int f, a1, a2, w;
         if (channel == CH_ENGINE) begin
            f = measure(0, stamp);
            if (f >= 0) rpm = (longint'(f) * 60 > RpmMax) ? RpmMax[22:0] : 23'(f * 60);
         end else if (channel == CH_WHEEL1 || channel == CH_WHEEL2) begin
            w = (channel == CH_WHEEL1) ? 0 : 1;
            f = measure(w + 1, stamp);
            if (f >= 0) begin
               history[w*2 + int'(slot[w])] = (f > int'(SpdMax)) ? SpdMax[16:0] : 17'(f);
               slot[w] = ~slot[w];
            end
            a1 = accel(0);
            a2 = accel(1);
            if (a1 == 0) begin
               slip = 0;
               fault = 1'b1;
            end else begin
               slip = ((a2 - a1) * 1000) / a1;
               fault = 1'b0;
            end
            slipping = speed() > speed_floor && rpm > min_rpm && slip > slip_limit;
         end
         a1 = accel(0);
         a2 = accel(1);
         r.engine_rpm = rpm;
         r.speed_hz = speed();
         r.acceleration = 16'((a1 >= a2) ? a1 : a2);
         r.slip_permille = 27'(slip);
         r.slipping = slipping;
         r.divide_fault = fault;
         pending_results.push_back(r);
      endfunction

      task check_result(slip_result_type got);
         slip_result_type want;
         if (pending_results.size() == 0) begin
            report("unexpected result count", 1, 0);
            return;
         end
         want = pending_results.pop_front();
         if (got.engine_rpm !== want.engine_rpm)
            report("engine_rpm", got.engine_rpm, want.engine_rpm);
         if (got.speed_hz !== want.speed_hz) report("speed_hz", got.speed_hz, want.speed_hz);
         if (got.acceleration !== want.acceleration)
            report("acceleration", got.acceleration, want.acceleration);
         if (got.slip_permille !== want.slip_permille)
            report("slip_permille", got.slip_permille, want.slip_permille);
         if (got.slipping !== want.slipping) report("slipping", got.slipping, want.slipping);
         if (got.divide_fault !== want.divide_fault)
            report("divide_fault", got.divide_fault, want.divide_fault);
      endtask
   endclass

   logic clock;
   logic reset;
   logic steady;
   logic [15:0] last_stamp[3];
   int unsigned last_period[3];

   wsd_req_if req_ch();
   wsd_rsp_if rsp_ch();
   wsd_csr_if csr_ch();

   slip_scoreboard slip_sb;

   wheel_slip_detector dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 29);
   end

   // Monitors sample accepted transactions at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) slip_sb.note_capture(req_ch.channel, req_ch.stamp);
         if (csr_ch.valid && csr_ch.ready) slip_sb.write_reg(csr_ch.index, csr_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            slip_result_type got;
            got.engine_rpm = rsp_ch.engine_rpm;
            got.speed_hz = rsp_ch.speed_hz;
            got.acceleration = rsp_ch.acceleration;
            got.slip_permille = rsp_ch.slip_permille;
            got.slipping = rsp_ch.slipping;
            got.divide_fault = rsp_ch.divide_fault;
            slip_sb.check_result(got);
         end
      end
   end

   task send_capture(logic [1:0] channel, logic [15:0] stamp);
      if (!steady && $urandom_range(99) < 29) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.channel = channel;
      req_ch.stamp = stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // Withdraw the transaction once it has been taken.
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task write_reg(logic [1:0] index, logic [26:0] data);
      @(negedge clock);
      req_ch.valid = 1'b0;
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task drain();
      while (slip_sb.pending_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task set_thresholds(int unsigned spd, int unsigned rpm_min, int thr);
      drain();
      write_reg(CSR_SPEED_FLOOR, 27'(spd));
      write_reg(CSR_MIN_RPM, 27'(rpm_min));
      write_reg(CSR_SLIP_THR, 27'(thr));
   endtask

   // Next edge on a channel: often short periods, some repeats for zero acceleration.
   task random_capture();
      int unsigned ch, sel, period;
      logic [15:0] stamp;
      sel = $urandom_range(99);
      if (sel < 4) begin
         send_capture(2'd3, 16'($urandom));
         return;
      end
      ch = (sel < 30) ? 0 : ((sel < 65) ? 1 : 2);
      sel = $urandom_range(99);
      if (sel < 25) period = last_period[ch];
      else if (sel < 70) period = $urandom_range(200, 1);
      else if (sel < 85) period = $urandom_range(65535, 200);
      else if (sel < 92) period = 0;
      else period = $urandom_range(65535);
      last_period[ch] = period;
      stamp = last_stamp[ch] + 16'(period);
      last_stamp[ch] = stamp;
      send_capture(2'(ch), stamp);
   endtask

   initial begin
      slip_sb = new();
      steady = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.channel = CH_ENGINE;
      req_ch.stamp = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_SPEED_FLOOR;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < 3; i++) begin
         last_stamp[i] = '0;
         last_period[i] = 1;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed edges with reset thresholds: ignored channel, equal and wrapped stamps,
      // shortest and longest periods, and repeated wheel periods for zero acceleration.
      send_capture(2'd3, 16'hFFFF);
      send_capture(CH_WHEEL1, 16'd0);
      send_capture(CH_ENGINE, 16'd0);
      send_capture(CH_ENGINE, 16'd0);
      send_capture(CH_ENGINE, 16'hFFFF);
      send_capture(CH_ENGINE, 16'd0);
      send_capture(CH_WHEEL1, 16'd5);
      send_capture(CH_WHEEL1, 16'd4);
      send_capture(CH_WHEEL2, 16'hFFFF);
      send_capture(CH_WHEEL2, 16'd0);
      send_capture(CH_WHEEL1, 16'd100);
      send_capture(CH_WHEEL1, 16'd101);
      send_capture(CH_WHEEL2, 16'd10);
      send_capture(CH_WHEEL2, 16'd10);
      send_capture(CH_WHEEL1, 16'd200);
      send_capture(CH_WHEEL1, 16'd201);
      send_capture(CH_WHEEL1, 16'd300);
      send_capture(CH_WHEEL1, 16'd301);
      send_capture(2'd3, 16'd0);

      // Random phases, each with its own thresholds.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_thresholds(0, 0, -65535000);
            1: set_thresholds(100000, 6000000, 65535000);
            2: set_thresholds(0, 0, 0);
            3: set_thresholds(50, 1000, -500);
            default: set_thresholds($urandom_range(2000), $urandom_range(200000),
                                    int'($urandom_range(4000)) - 2000);
         endcase
         for (int i = 0; i < 110; i++) begin
            steady = (phase == 2 && i >= 20 && i < 90);
            if (phase == 3 && i == 50) drain();
            random_capture();
         end
         steady = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      while (slip_sb.pending_results.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (slip_sb.mismatches == 0 && slip_sb.pending_results.size() == 0) begin
         $display("wheel_slip_detector: match");
      end else begin
         $display("wheel_slip_detector: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("wheel_slip_detector: mismatch");
      $finish;
   end

endmodule
